### hw/rtl/fold_op_alu_top_defines.svh
// Assertion macros for the fold operation ALU.
`ifndef FOLD_OP_ALU_TOP_DEFINES_SVH
`define FOLD_OP_ALU_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define FOA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define FOA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/foa_pkg.sv
// Package: opcodes, status codes and sideband type of the fold operation ALU.
`timescale 1ns / 1ps
`default_nettype none
package foa_pkg;
   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_BIND    = 4'd1;
   localparam logic [3:0] OP_DIV     = 4'd2;
   localparam logic [3:0] OP_EQ      = 4'd3;
   localparam logic [3:0] OP_EWMA    = 4'd4;
   localparam logic [3:0] OP_GT      = 4'd5;
   localparam logic [3:0] OP_IFSET   = 4'd6;
   localparam logic [3:0] OP_LT      = 4'd8;
   localparam logic [3:0] OP_MAX     = 4'd9;
   localparam logic [3:0] OP_MIN     = 4'd10;
   localparam logic [3:0] OP_MUL     = 4'd11;
   localparam logic [3:0] OP_IFCLEAR = 4'd12;
   localparam logic [3:0] OP_SUB     = 4'd13;
   localparam logic [3:0] OP_DEFINE  = 4'd14;
   localparam logic [3:0] OP_WRAPMAX = 4'd15;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADOP   = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;

   typedef struct packed {
      logic [63:0] res;
      logic        we;
      logic [1:0]  st;
      logic        use_div;
   } foa_tag_type;
endpackage
`default_nettype wire

### hw/rtl/foa_if.sv
// Stream interfaces for request and response beats.
`timescale 1ns / 1ps
`default_nettype none
interface foa_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [63:0] left_value;
   logic [63:0] right_value;
   logic [63:0] current_value;
   modport source (output valid, operation, left_value, right_value, current_value,
                   input ready);
   modport sink (input valid, operation, left_value, right_value, current_value,
                 output ready);
endinterface

interface foa_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_value;
   logic        write_enable;
   logic [1:0]  status;
   modport source (output valid, result_value, write_enable, status, input ready);
   modport sink (input valid, result_value, write_enable, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/foa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module foa_div_pipe (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  wire                  in_vld,
   input  wire [63:0]           in_dvd,
   input  wire [63:0]           in_dvs,
   input  foa_pkg::foa_tag_type in_tag,
   output logic                 out_vld,
   output logic [63:0]          out_q,
   output foa_pkg::foa_tag_type out_tag
);
   import foa_pkg::*;

   localparam int NSTG = 64;

   logic        vld_ff [1:NSTG];
   logic [63:0] rem_ff [1:NSTG];
   logic [63:0] dq_ff  [1:NSTG];
   logic [63:0] dvs_ff [1:NSTG];
   foa_tag_type tag_ff [1:NSTG];

   for (genvar i = 0; i < NSTG; i++) begin : g_stg
      logic        vld_cur;
      logic [63:0] rem_cur;
      logic [63:0] dq_cur;
      logic [63:0] dvs_cur;
      foa_tag_type tag_cur;
      logic [64:0] trial_in;
      logic [64:0] diff_in;
      logic        qbit_in;
      if (i == 0) begin : g_head
         assign vld_cur = in_vld;
         assign rem_cur = '0;
         assign dq_cur  = in_dvd;
         assign dvs_cur = in_dvs;
         assign tag_cur = in_tag;
      end else begin : g_body
         assign vld_cur = vld_ff[i];
         assign rem_cur = rem_ff[i];
         assign dq_cur  = dq_ff[i];
         assign dvs_cur = dvs_ff[i];
         assign tag_cur = tag_ff[i];
      end
      always_comb begin
         trial_in = {rem_cur, dq_cur[63]};
         diff_in  = trial_in - {1'b0, dvs_cur};
         qbit_in  = !diff_in[64];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_cur;
         end
         if (en) begin
            rem_ff[i+1] <= qbit_in ? diff_in[63:0] : trial_in[63:0];
            dq_ff[i+1]  <= {dq_cur[62:0], qbit_in};
            dvs_ff[i+1] <= dvs_cur;
            tag_ff[i+1] <= tag_cur;
         end
      end
   end

   assign out_vld = vld_ff[NSTG];
   assign out_q   = dq_ff[NSTG];
   assign out_tag = tag_ff[NSTG];
endmodule
`default_nettype wire

### hw/rtl/fold_op_alu_top.sv
// Top level of the fold operation ALU: decode, multiply, divide and output stages.
// Every request beat takes the same path to its response beat (two front stages,
// 64 divider stages, one output register), whatever its opcode.
// Throughput: one beat per cycle; the whole pipe holds while the output waits.
// Reset clears every stage valid bit and the output valid; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "fold_op_alu_top_defines.svh"
module fold_op_alu_top #(
   parameter int EWMA_DENOMINATOR = 10
) (
   input  wire    clock,
   input  wire    reset,
   foa_req_if.sink   req,
   foa_rsp_if.source rsp
);
   import foa_pkg::*;

   localparam logic [1:0] K_SIMPLE = 2'd0;
   localparam logic [1:0] K_MUL    = 2'd1;
   localparam logic [1:0] K_DIV    = 2'd2;
   localparam logic [1:0] K_EWMA   = 2'd3;
   localparam logic [63:0] DENOM   = 64'(EWMA_DENOMINATOR);

   logic adv;
   logic rsp_vld_ff;
   assign adv = !rsp_vld_ff || rsp.ready;
   assign req.ready = adv;

   // stage 1: decode, partial products
   logic [3:0]  op;
   logic [63:0] l, r, cur, mb, na;
   logic [63:0] sres_in;
   logic        swe_in;
   logic [1:0]  sst_in;
   logic [1:0]  kind_in;
   logic [31:0] fwd_rl, fwd_lr;

   assign op  = req.operation;
   assign l   = req.left_value;
   assign r   = req.right_value;
   assign cur = req.current_value;
   assign mb  = (op == OP_MUL) ? r : cur;
   assign na  = DENOM - l;
   assign fwd_rl = (l[31:0] > r[31:0]) ? l[31:0] - r[31:0] : ~r[31:0] + l[31:0];
   assign fwd_lr = (r[31:0] > l[31:0]) ? r[31:0] - l[31:0] : ~l[31:0] + r[31:0];

   always_comb begin
      sres_in = '0;
      swe_in  = 1'b1;
      sst_in  = ST_OK;
      kind_in = K_SIMPLE;
      unique case (op)
         OP_ADD:  sres_in = l + r;
         OP_BIND: sres_in = r;
         OP_DIV: begin
            if (r == '0) begin
               sres_in = '1;
               sst_in  = ST_DIVZERO;
            end else begin
               kind_in = K_DIV;
            end
         end
         OP_EQ: sres_in = {63'd0, l == r};
         OP_EWMA: begin
            if (cur == '0) begin
               sres_in = r;
            end else begin
               kind_in = K_EWMA;
            end
         end
         OP_GT: sres_in = {63'd0, l > r};
         OP_IFSET: begin
            if (l == 64'd1) begin
               sres_in = r;
            end else begin
               swe_in = 1'b0;
            end
         end
         OP_LT:  sres_in = {63'd0, l < r};
         OP_MAX: sres_in = (l > r) ? l : r;
         OP_MIN: sres_in = (l < r) ? l : r;
         OP_MUL: kind_in = K_MUL;
         OP_IFCLEAR: begin
            if (l == '0) begin
               sres_in = r;
            end else begin
               swe_in = 1'b0;
            end
         end
         OP_SUB:    sres_in = l - r;
         OP_DEFINE: swe_in = 1'b0;
         OP_WRAPMAX: begin
            if (l == '0) begin
               sres_in = r;
            end else if (r == '0) begin
               sres_in = l;
            end else if (fwd_rl < fwd_lr) begin
               sres_in = {32'd0, l[31:0]};
            end else begin
               sres_in = {32'd0, r[31:0]};
            end
         end
         default: begin
            swe_in = 1'b0;
            sst_in = ST_BADOP;
         end
      endcase
   end

   logic [63:0] m1ll_in, m1lh_in, m1hl_in, m2ll_in, m2lh_in, m2hl_in;
   assign m1ll_in = l[31:0] * mb[31:0];
   assign m1lh_in = l[31:0] * mb[63:32];
   assign m1hl_in = l[63:32] * mb[31:0];
   assign m2ll_in = na[31:0] * r[31:0];
   assign m2lh_in = na[31:0] * r[63:32];
   assign m2hl_in = na[63:32] * r[31:0];

   logic        v1_ff;
   logic [63:0] m1ll_ff, m2ll_ff, sres_ff, l1_ff, r1_ff;
   logic [31:0] m1lh_ff, m1hl_ff, m2lh_ff, m2hl_ff;
   logic        swe_ff;
   logic [1:0]  sst_ff, kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
      end
      if (adv) begin
         m1ll_ff <= m1ll_in;
         m1lh_ff <= m1lh_in[31:0];
         m1hl_ff <= m1hl_in[31:0];
         m2ll_ff <= m2ll_in;
         m2lh_ff <= m2lh_in[31:0];
         m2hl_ff <= m2hl_in[31:0];
         sres_ff <= sres_in;
         swe_ff  <= swe_in;
         sst_ff  <= sst_in;
         kind_ff <= kind_in;
         l1_ff   <= l;
         r1_ff   <= r;
      end
   end

   // stage 2: sum products, pick dividend and divisor
   logic [63:0] p1, p2;
   logic [31:0] x1, x2;
   logic [63:0] dvd_in, dvs_in;
   foa_tag_type tag_in;

   assign x1 = m1lh_ff + m1hl_ff;
   assign x2 = m2lh_ff + m2hl_ff;
   assign p1 = m1ll_ff + {x1, 32'd0};
   assign p2 = m2ll_ff + {x2, 32'd0};

   always_comb begin
      dvd_in      = l1_ff;
      dvs_in      = r1_ff;
      tag_in.res  = sres_ff;
      tag_in.we   = swe_ff;
      tag_in.st   = sst_ff;
      tag_in.use_div = 1'b0;
      case (kind_ff)
         K_MUL: tag_in.res = p1;
         K_DIV: tag_in.use_div = 1'b1;
         K_EWMA: begin
            dvd_in = p1 + p2;
            dvs_in = DENOM;
            tag_in.use_div = 1'b1;
         end
         default: tag_in.use_div = 1'b0;
      endcase
   end

   logic        v2_ff;
   logic [63:0] dvd_ff, dvs_ff;
   foa_tag_type tag2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         dvd_ff  <= dvd_in;
         dvs_ff  <= dvs_in;
         tag2_ff <= tag_in;
      end
   end

   logic        dv_vld;
   logic [63:0] dv_q;
   foa_tag_type dv_tag;

   foa_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (v2_ff),
      .in_dvd  (dvd_ff),
      .in_dvs  (dvs_ff),
      .in_tag  (tag2_ff),
      .out_vld (dv_vld),
      .out_q   (dv_q),
      .out_tag (dv_tag)
   );

   // output register
   logic [63:0] res_ff;
   logic        we_ff;
   logic [1:0]  st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_vld;
      end
      if (adv) begin
         res_ff <= !dv_tag.we ? '0 : (dv_tag.use_div ? dv_q : dv_tag.res);
         we_ff  <= dv_tag.we;
         st_ff  <= dv_tag.st;
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.result_value = res_ff;
   assign rsp.write_enable = we_ff;
   assign rsp.status       = st_ff;

   `FOA_ASSERT_NOW(a_we_zero, rsp_vld_ff && !we_ff, res_ff == '0, "result set without write")
   `FOA_ASSERT_NOW(a_divzero, rsp_vld_ff && st_ff == ST_DIVZERO, we_ff && &res_ff, "bad div0 beat")
   `FOA_ASSERT_NOW(a_badop, rsp_vld_ff && st_ff == ST_BADOP, !we_ff, "invalid opcode writes")
   `FOA_ASSERT_NEXT(a_enter, req.valid && req.ready, v1_ff, "accepted beat lost at entry")
endmodule
`default_nettype wire
